@@ sv/psd_pkg.sv @@
`default_nettype none

package psd_pkg;

    // Register map of the configuration port
    localparam logic [2:0] REG_INTERVAL   = 3'd0;
    localparam logic [2:0] REG_MAX_READ   = 3'd1;
    localparam logic [2:0] REG_MIN_MEAN   = 3'd2;
    localparam logic [2:0] REG_SPREAD_LIM = 3'd3;
    localparam logic [2:0] REG_GAIN       = 3'd4;

    localparam logic [15:0] RST_INTERVAL   = 16'd50;
    localparam logic [5:0]  RST_MAX_READ   = 6'd50;
    localparam logic [15:0] RST_MIN_MEAN   = 16'd1280;
    localparam logic [31:0] RST_SPREAD_LIM = 32'd131072;
    localparam logic [15:0] RST_GAIN       = 16'd18569;

    typedef enum logic [1:0] {
        STAT_BUSY     = 2'd0,
        STAT_STABLE   = 2'd1,
        STAT_UNSTABLE = 2'd2
    } status_t;

    // What the front decided for one poll
    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_SKIP   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_SUM    = 3'd1,
        ST_MEAN   = 3'd2,
        ST_SPREAD = 3'd3,
        ST_CHECK  = 3'd4,
        ST_EMIT   = 3'd5
    } state_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [11:0] adc_reading;
    } poll_t;

    typedef struct packed {
        status_t     status;
        logic        close_valves;
        logic        sample_taken;
        logic [15:0] pressure_q8;
        logic [15:0] mean_q8;
        logic [7:0]  rounded_psi;
    } result_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] pressure;
    } work_t;

    // Completion of one word by the back part
    typedef struct packed {
        logic fire;
        logic ended;
    } done_t;

    typedef struct packed {
        logic [15:0] sample_interval_ms;
        logic [5:0]  max_readings;
        logic [15:0] min_mean_q8;
        logic [31:0] spread_limit;
        logic [15:0] gain_q12;
    } cfg_t;

endpackage

`default_nettype wire

@@ sv/pressure_stability_detector.sv @@
// Pressure stability detector.
// Poll channel (push/full, word poll): one poll carries now_ms and adc_reading.
// Report channel (empty/pop, word report): exactly one report per poll, in order.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle:
//   0 sample_interval_ms, 1 max_readings, 2 min_mean_q8, 3 spread_limit,
//   4 gain_q12; other indexes are ignored. Write only while no poll is pending.
// The front classifies a poll (start, sample, skip) and converts the reading;
// a two-word queue hands it to the back, which owns the sample ring and runs
// the window passes. One poll is in flight at a time; full rises on accept.
// Path: the front pushes the classified word into the work queue; the back
// pops it and sends a start or a skip straight to emit, a sample with a
// partial window through the check to emit, and a sample that completes the
// window through a sum pass, a mean step, a spread pass and the check. The
// next poll is taken the cycle after the report enters the two-word output
// queue, so a new poll is not accepted before the last one is reported.
// Reset: idle, counters cleared, registers at their defaults; ring contents
// need no clearing since the window is read only once it is full.
// A stalled receiver fills the output queue; the back then holds its report
// and full stays high until room appears.
`default_nettype none

module pressure_stability_detector
    import psd_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire poll_t       poll,
    output logic             empty,
    input  wire logic        pop,
    output result_t          report,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    logic    wq_push, wq_pop, wq_full, wq_empty;
    work_t   wq_in, wq_out;
    logic [$bits(work_t)-1:0]   wq_bits;
    logic    res_push, res_full;
    result_t res_data;
    logic [$bits(result_t)-1:0] res_bits;
    done_t   done;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_INTERVAL:   cfg_next.sample_interval_ms = cfg_data[15:0];
                REG_MAX_READ:   cfg_next.max_readings       = cfg_data[5:0];
                REG_MIN_MEAN:   cfg_next.min_mean_q8        = cfg_data[15:0];
                REG_SPREAD_LIM: cfg_next.spread_limit       = cfg_data;
                REG_GAIN:       cfg_next.gain_q12           = cfg_data[15:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_interval_ms <= RST_INTERVAL;
            cfg_reg.max_readings       <= RST_MAX_READ;
            cfg_reg.min_mean_q8        <= RST_MIN_MEAN;
            cfg_reg.spread_limit       <= RST_SPREAD_LIM;
            cfg_reg.gain_q12           <= RST_GAIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    psd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .poll    (poll),
        .cfg     (cfg_reg),
        .done    (done),
        .wq_push (wq_push),
        .wq_item (wq_in)
    );

    psd_fifo #(.W($bits(work_t))) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (wq_push),
        .wdata (wq_in),
        .full  (wq_full),
        .pop   (wq_pop),
        .rdata (wq_bits),
        .empty (wq_empty)
    );

    assign wq_out = work_t'(wq_bits);

    psd_back #(.WINDOW(WINDOW)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .wq_empty (wq_empty),
        .wq_item  (wq_out),
        .wq_pop   (wq_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_data),
        .done     (done)
    );

    psd_fifo #(.W($bits(result_t))) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign report = result_t'(res_bits);

    a_work_q_room: assert property (@(posedge clk) disable iff (!rst_n)
        wq_push |-> !wq_full)
        else $error("work queue overflow");

endmodule

`default_nettype wire

@@ sv/psd_fifo.sv @@
`default_nettype none

module psd_fifo #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      rdata,
    output logic              empty
);

    localparam int DEPTH = 2;

    logic [W-1:0] mem_reg [DEPTH];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push, do_pop;

    assign full    = (count_reg == 2'(DEPTH));
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the stored words
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ sv/psd_front.sv @@
`default_nettype none

module psd_front
    import psd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire poll_t poll,
    input  wire cfg_t  cfg,
    input  wire done_t done,
    output logic       wq_push,
    output work_t      wq_item
);

    logic        active_reg, active_next;
    logic        busy_reg, busy_next;
    logic [31:0] last_time_reg, last_time_next;
    logic        accept;
    logic [31:0] elapsed;
    logic        due;
    logic [27:0] prod;

    assign accept = push && !busy_reg;
    assign full   = busy_reg;

    // Classify the poll: start, sample or skip
    always_comb
    begin
        elapsed = poll.now_ms - last_time_reg;
        due     = (elapsed >= {16'd0, cfg.sample_interval_ms});
        // 12-bit reading times 16-bit gain, shifted by 12, never exceeds 16 bits
        prod    = {16'd0, poll.adc_reading} * {12'd0, cfg.gain_q12};
        wq_item.pressure = 16'd0;
        if (!active_reg)
        begin
            wq_item.kind = KIND_START;
        end
        else if (due)
        begin
            wq_item.kind     = KIND_SAMPLE;
            wq_item.pressure = prod[27:12];
        end
        else
        begin
            wq_item.kind = KIND_SKIP;
        end
        wq_push = accept;
    end

    // Track measurement state and the word in flight
    always_comb
    begin
        active_next    = active_reg;
        busy_next      = busy_reg;
        last_time_next = last_time_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            if (wq_item.kind != KIND_SKIP)
            begin
                last_time_next = poll.now_ms;
            end
            if (wq_item.kind == KIND_START)
            begin
                active_next = 1'b1;
            end
        end
        else if (done.fire)
        begin
            busy_next = 1'b0;
            if (done.ended)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            busy_reg      <= 1'b0;
            last_time_reg <= 32'd0;
        end
        else
        begin
            active_reg    <= active_next;
            busy_reg      <= busy_next;
            last_time_reg <= last_time_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/psd_back.sv @@
`default_nettype none

module psd_back
    import psd_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  wq_empty,
    input  wire work_t wq_item,
    output logic       wq_pop,
    input  wire logic  res_full,
    output logic       res_push,
    output result_t    res_data,
    output done_t      done
);

    localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int LOG_W   = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int SUM_W   = 16 + LOG_W;
    localparam int SPR_W   = 32 + LOG_W;
    localparam int K       = SUM_W + LOG_W;
    localparam int RECIP_W = SUM_W + 1;
    localparam int MPROD_W = SUM_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << K) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);

    state_t             state_reg, state_next;
    logic [15:0]        ring [WINDOW];
    logic [15:0]        rd_data_reg;
    logic               rd_valid_reg, rd_valid_next;
    logic [31:0]        sq_reg, sq_next;
    logic               sq_valid_reg, sq_valid_next;
    logic [IDX_W-1:0]   wptr_reg, wptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [5:0]         readings_reg, readings_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [15:0]        mean_reg, mean_next;
    logic [SPR_W-1:0]   spread_reg, spread_next;
    logic [15:0]        pres_reg, pres_next;
    result_t            res_reg, res_next;
    logic               ended_reg, ended_next;
    logic               ring_we;
    logic               rd_en;
    logic [CNT_W-1:0]   fill_inc;
    logic               cnt_done;
    logic [MPROD_W-1:0] mprod;
    logic [15:0]        dev;
    logic               stable;
    logic [8:0]         rnd;

    assign cnt_done = (cnt_reg == CNT_W'(WINDOW));
    assign fill_inc = (fill_reg < CNT_W'(WINDOW)) ? fill_reg + CNT_W'(1) : fill_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!wq_empty)
                begin
                    if (wq_item.kind == KIND_SAMPLE)
                    begin
                        state_next = (fill_inc == CNT_W'(WINDOW)) ? ST_SUM : ST_CHECK;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SUM:
            begin
                if (cnt_done && !rd_valid_reg)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                state_next = ST_SPREAD;
            end
            ST_SPREAD:
            begin
                if (cnt_done && !rd_valid_reg && !sq_valid_reg)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        wptr_next     = wptr_reg;
        fill_next     = fill_reg;
        readings_next = readings_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        mean_next     = mean_reg;
        spread_next   = spread_reg;
        pres_next     = pres_reg;
        res_next      = res_reg;
        ended_next    = ended_reg;
        rd_valid_next = 1'b0;
        sq_next       = sq_reg;
        sq_valid_next = 1'b0;
        ring_we       = 1'b0;
        rd_en         = 1'b0;
        wq_pop        = 1'b0;
        res_push      = 1'b0;
        done          = '0;
        mprod         = MPROD_W'(sum_reg) * MPROD_W'(RECIP_W'(RECIP));
        dev           = (rd_data_reg >= mean_reg) ? rd_data_reg - mean_reg
                                                  : mean_reg - rd_data_reg;
        stable        = (fill_reg == CNT_W'(WINDOW))
                        && (spread_reg < SPR_W'(cfg.spread_limit))
                        && (mean_reg >= cfg.min_mean_q8);
        rnd           = 9'(({1'b0, mean_reg} + 17'd128) >> 8);
        case (state_reg)
            ST_IDLE:
            begin
                if (!wq_empty)
                begin
                    wq_pop     = 1'b1;
                    res_next   = '0;
                    ended_next = 1'b0;
                    case (wq_item.kind)
                        KIND_START:
                        begin
                            wptr_next             = '0;
                            fill_next             = '0;
                            readings_next         = '0;
                            res_next.close_valves = 1'b1;
                        end
                        KIND_SAMPLE:
                        begin
                            ring_we       = 1'b1;
                            pres_next     = wq_item.pressure;
                            wptr_next     = (wptr_reg == IDX_W'(WINDOW - 1))
                                            ? '0 : wptr_reg + IDX_W'(1);
                            fill_next     = fill_inc;
                            readings_next = readings_reg + 6'd1;
                            cnt_next      = '0;
                            sum_next      = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SUM:
            begin
                // Add one stored sample per cycle
                if (!cnt_done)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    cnt_next      = cnt_reg + CNT_W'(1);
                end
                if (rd_valid_reg)
                begin
                    sum_next = sum_reg + SUM_W'(rd_data_reg);
                end
            end
            ST_MEAN:
            begin
                // Divide by the window size through a rounded-up reciprocal
                mean_next   = mprod[K +: 16];
                cnt_next    = '0;
                spread_next = '0;
            end
            ST_SPREAD:
            begin
                // Square each deviation into a register, then accumulate it in the next cycle
                if (!cnt_done)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    cnt_next      = cnt_reg + CNT_W'(1);
                end
                if (rd_valid_reg)
                begin
                    sq_next       = {16'd0, dev} * {16'd0, dev};
                    sq_valid_next = 1'b1;
                end
                if (sq_valid_reg)
                begin
                    spread_next = spread_reg + SPR_W'(sq_reg);
                end
            end
            ST_CHECK:
            begin
                res_next              = '0;
                res_next.sample_taken = 1'b1;
                res_next.pressure_q8  = pres_reg;
                ended_next            = 1'b0;
                if (stable)
                begin
                    res_next.status      = STAT_STABLE;
                    res_next.mean_q8     = mean_reg;
                    res_next.rounded_psi = rnd[8] ? 8'hFF : rnd[7:0];
                    ended_next           = 1'b1;
                end
                else if (readings_reg >= cfg.max_readings)
                begin
                    res_next.status = STAT_UNSTABLE;
                    ended_next      = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    done.fire  = 1'b1;
                    done.ended = ended_reg;
                end
            end
            default:
            begin
            end
        endcase
        res_data = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wptr_reg     <= '0;
            fill_reg     <= '0;
            readings_reg <= '0;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
            ended_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wptr_reg     <= wptr_next;
            fill_reg     <= fill_next;
            readings_reg <= readings_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_valid_next;
            sq_valid_reg <= sq_valid_next;
            ended_reg    <= ended_next;
        end
    end

    // Hold payload and arithmetic results
    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        mean_reg   <= mean_next;
        spread_reg <= spread_next;
        sq_reg     <= sq_next;
        pres_reg   <= pres_next;
        res_reg    <= res_next;
    end

    // Sample ring: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring[wptr_reg] <= wq_item.pressure;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring[cnt_reg[IDX_W-1:0]];
        end
    end

    a_sum_full_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (fill_reg == CNT_W'(WINDOW)))
        else $error("window pass started before the ring was full");

    a_stable_mean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_data.status == STAT_STABLE)
        |-> (res_data.mean_q8 >= cfg.min_mean_q8 && res_data.sample_taken))
        else $error("stable word without an accepted mean and sample");

    a_start_word: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_data.close_valves)
        |-> (res_data.status == STAT_BUSY && !res_data.sample_taken))
        else $error("start word carries a sample or a verdict");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (done.fire && done.ended)
        |-> (res_data.status == STAT_STABLE || res_data.status == STAT_UNSTABLE))
        else $error("measurement ended without a verdict");

endmodule

`default_nettype wire
